### sv/sfg_pkg.sv
package sfg_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int XW        = 32;           // coordinate / register word
    localparam int NL        = 3;            // vector lanes x, y, z
    localparam int AD_W      = 32;           // |pos - end| fits 32 bits unsigned
    localparam int SQ_W      = 2 * AD_W;     // one squared component
    localparam int SUM_W     = 66;           // sum of three squares
    localparam int LEN_W     = SUM_W / 2;    // root width
    localparam int REST_W    = 31;
    localparam int STR_W     = LEN_W;        // stretch
    localparam int PROD_W    = XW + STR_W;   // stiffness * stretch
    localparam int PLO_W     = 33;           // low slice of the product
    localparam int PHI_W     = PROD_W - PLO_W;
    localparam int MLO_W     = PLO_W + AD_W;
    localparam int MHI_W     = PHI_W + AD_W;
    localparam int NUM_W     = PLO_W + MHI_W;
    localparam int Q_W       = 32;           // quotient bits kept
    localparam int IN_W      = 2 * NL * XW;
    localparam int OUT_W     = NL * XW;
    localparam int USER_W    = 2;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STIFFNESS   = 2'd0,
        REG_REST_LENGTH = 2'd1,
        REG_BUNGEE_MODE = 2'd2
    } cfg_reg_t;

    // rides along the square root pipeline
    typedef struct packed {
        logic [NL-1:0][AD_W-1:0] ad;
        logic [NL-1:0]           dir;
    } sq_tag_t;

    // rides along the divider pipeline
    typedef struct packed {
        logic [NL-1:0] dir;   // separation positive: force points negative
        logic [NL-1:0] nz;    // component nonzero
        logic          slack;
    } div_tag_t;

endpackage

### sv/spring_force_generator.sv
// Channel  Direction  Content
// cfg      in         register index, write data
// s_       in         particle position and other end, x y z each
// m_       out        force x y z; tuser applied, saturated
//
// A beat is accepted every cycle while the output buffer has room.
// A result passes through three front stages, a 33-stage square root, five
// multiply stages and a 33-stage divider, then enters the output buffer.
// Reset (aresetn low, synchronous) empties the pipe and loads register defaults.
// A two-entry output buffer takes results while m_tready is low; the whole
// pipe holds only when that buffer is full.
module spring_force_generator #(
    parameter int FRAC_BITS = sfg_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sfg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfg_pkg::XW-1:0]         cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pos_x, pos_y, pos_z, end_x, end_y, end_z
    input  logic [sfg_pkg::IN_W-1:0]       s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // force_x, force_y, force_z
    output logic [sfg_pkg::OUT_W-1:0]      m_tdata,
    // applied, saturated
    output logic [sfg_pkg::USER_W-1:0]     m_tuser
);
    import sfg_pkg::*;

    localparam int DEN_W = LEN_W + FRAC_BITS;

    // ---------------- configuration ----------------
    logic [XW-1:0]     stiff_reg;
    logic [REST_W-1:0] rest_reg;
    logic              bungee_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiff_reg  <= XW'(65536);
            rest_reg   <= REST_W'(65536);
            bungee_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_STIFFNESS:   stiff_reg  <= cfg_data;
                REG_REST_LENGTH: rest_reg   <= cfg_data[REST_W-1:0];
                REG_BUNGEE_MODE: bungee_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic [1:0] cnt_reg;
    logic       en;

    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;

    // ---------------- S1: separation ----------------
    logic            s1_vld_reg;
    logic [AD_W-1:0] s1_ad_reg [NL];
    logic [NL-1:0]   s1_dir_reg;
    logic [AD_W-1:0] s1_ad_next [NL];
    logic [NL-1:0]   s1_dir_next;

    always_comb begin
        logic [XW:0] d;
        logic [XW:0] nd;
        for (int i = 0; i < NL; i++) begin
            d  = {s_tdata[i*XW + XW-1], s_tdata[i*XW +: XW]}
               - {s_tdata[(i+NL)*XW + XW-1], s_tdata[(i+NL)*XW +: XW]};
            nd = -d;
            s1_ad_next[i]  = d[XW] ? nd[AD_W-1:0] : d[AD_W-1:0];
            s1_dir_next[i] = ~d[XW] & (d != '0);
        end
    end

    // ---------------- S2: squares ----------------
    logic            s2_vld_reg;
    logic [SQ_W-1:0] s2_sq_reg [NL];
    logic [AD_W-1:0] s2_ad_reg [NL];
    logic [NL-1:0]   s2_dir_reg;

    // ---------------- S3: sum ----------------
    logic             s3_vld_reg;
    logic [SUM_W-1:0] s3_sum_reg;
    sq_tag_t          s3_tag_reg;
    logic [SUM_W-1:0] s3_sum_next;
    sq_tag_t          s3_tag_next;

    always_comb begin
        s3_sum_next = SUM_W'(s2_sq_reg[0]) + SUM_W'(s2_sq_reg[1]) + SUM_W'(s2_sq_reg[2]);
        for (int i = 0; i < NL; i++) begin
            s3_tag_next.ad[i] = s2_ad_reg[i];
        end
        s3_tag_next.dir = s2_dir_reg;
    end

    // ---------------- square root ----------------
    logic             sq_vld;
    logic [LEN_W-1:0] sq_len;
    sq_tag_t          sq_tag;

    sfg_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s3_vld_reg),
        .in_rad   (s3_sum_reg),
        .in_tag   (s3_tag_reg),
        .out_vld  (sq_vld),
        .out_root (sq_len),
        .out_tag  (sq_tag)
    );

    // ---------------- S4: stretch ----------------
    logic             s4_vld_reg;
    logic [LEN_W-1:0] s4_len_reg;
    logic [STR_W-1:0] s4_str_reg;
    logic             s4_slack_reg;
    sq_tag_t          s4_tag_reg;
    logic [STR_W-1:0] s4_str_next;
    logic             s4_slack_next;

    always_comb begin
        logic [LEN_W-1:0] rest;
        rest          = LEN_W'(rest_reg);
        s4_slack_next = bungee_reg & (sq_len <= rest);
        s4_str_next   = (sq_len >= rest) ? (sq_len - rest) : (rest - sq_len);
    end

    // ---------------- S5: stiffness * stretch, low part ----------------
    logic             s5_vld_reg;
    logic [2*XW-1:0]  s5_pl_reg;
    logic             s5_b32_reg;
    logic [LEN_W-1:0] s5_len_reg;
    logic             s5_slack_reg;
    sq_tag_t          s5_tag_reg;

    // ---------------- S6: fold top stretch bit ----------------
    logic              s6_vld_reg;
    logic [PROD_W-1:0] s6_p_reg;
    logic [LEN_W-1:0]  s6_len_reg;
    logic              s6_slack_reg;
    sq_tag_t           s6_tag_reg;
    logic [PROD_W-1:0] s6_p_next;

    assign s6_p_next = PROD_W'(s5_pl_reg)
                     + (s5_b32_reg ? {1'b0, stiff_reg, {XW{1'b0}}} : '0);

    // ---------------- S7: partial products per lane ----------------
    logic             s7_vld_reg;
    logic [MLO_W-1:0] s7_mlo_reg [NL];
    logic [MHI_W-1:0] s7_mhi_reg [NL];
    logic [LEN_W-1:0] s7_len_reg;
    logic             s7_slack_reg;
    sq_tag_t          s7_tag_reg;

    // ---------------- S8: numerator, denominator ----------------
    logic             s8_vld_reg;
    logic [NUM_W-1:0] s8_num_reg [NL];
    logic [DEN_W-1:0] s8_den_reg;
    div_tag_t         s8_tag_reg;
    div_tag_t         s8_tag_next;

    always_comb begin
        s8_tag_next.slack = s7_slack_reg;
        s8_tag_next.dir   = s7_tag_reg.dir;
        for (int i = 0; i < NL; i++) begin
            s8_tag_next.nz[i] = (s7_tag_reg.ad[i] != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_tvalid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= sq_vld;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
            s8_vld_reg <= s7_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NL; i++) begin
                s1_ad_reg[i]  <= s1_ad_next[i];
                s2_sq_reg[i]  <= s1_ad_reg[i] * s1_ad_reg[i];
                s2_ad_reg[i]  <= s1_ad_reg[i];
                s7_mlo_reg[i] <= MLO_W'(s6_p_reg[PLO_W-1:0]) * MLO_W'(s6_tag_reg.ad[i]);
                s7_mhi_reg[i] <= MHI_W'(s6_p_reg[PROD_W-1:PLO_W]) * MHI_W'(s6_tag_reg.ad[i]);
                s8_num_reg[i] <= NUM_W'(s7_mlo_reg[i]) + {s7_mhi_reg[i], {PLO_W{1'b0}}};
            end
            s1_dir_reg   <= s1_dir_next;
            s2_dir_reg   <= s1_dir_reg;
            s3_sum_reg   <= s3_sum_next;
            s3_tag_reg   <= s3_tag_next;
            s4_len_reg   <= sq_len;
            s4_str_reg   <= s4_str_next;
            s4_slack_reg <= s4_slack_next;
            s4_tag_reg   <= sq_tag;
            s5_pl_reg    <= (2*XW)'(stiff_reg) * (2*XW)'(s4_str_reg[XW-1:0]);
            s5_b32_reg   <= s4_str_reg[STR_W-1];
            s5_len_reg   <= s4_len_reg;
            s5_slack_reg <= s4_slack_reg;
            s5_tag_reg   <= s4_tag_reg;
            s6_p_reg     <= s6_p_next;
            s6_len_reg   <= s5_len_reg;
            s6_slack_reg <= s5_slack_reg;
            s6_tag_reg   <= s5_tag_reg;
            s7_len_reg   <= s6_len_reg;
            s7_slack_reg <= s6_slack_reg;
            s7_tag_reg   <= s6_tag_reg;
            s8_den_reg   <= {s7_len_reg, {FRAC_BITS{1'b0}}};
            s8_tag_reg   <= s8_tag_next;
        end
    end

    // ---------------- divider ----------------
    logic           dv_vld;
    logic [Q_W-1:0] dv_q [NL];
    logic [NL-1:0]  dv_ovf;
    div_tag_t       dv_tag;

    sfg_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s8_vld_reg),
        .in_num  (s8_num_reg),
        .in_den  (s8_den_reg),
        .in_tag  (s8_tag_reg),
        .out_vld (dv_vld),
        .out_q   (dv_q),
        .out_ovf (dv_ovf),
        .out_tag (dv_tag)
    );

    // ---------------- clip and sign ----------------
    logic [OUT_W-1:0]  fin_data;
    logic [USER_W-1:0] fin_user;

    always_comb begin
        logic [XW-1:0] lim;
        logic [XW-1:0] mag;
        logic [XW-1:0] nmag;
        logic          over;
        logic          sat;
        sat = 1'b0;
        for (int i = 0; i < NL; i++) begin
            lim  = dv_tag.dir[i] ? 32'h8000_0000 : 32'h7fff_ffff;
            over = dv_ovf[i] | (dv_q[i] > lim);
            mag  = over ? lim : dv_q[i];
            nmag = -mag;
            if (dv_tag.slack || !dv_tag.nz[i]) begin
                fin_data[i*XW +: XW] = '0;
            end else begin
                fin_data[i*XW +: XW] = dv_tag.dir[i] ? nmag : mag;
                sat = sat | over;
            end
        end
        fin_user[0] = ~dv_tag.slack;
        fin_user[1] = sat;
    end

    // ---------------- output buffer ----------------
    logic [OUT_W-1:0]  e0_data_reg, e1_data_reg;
    logic [USER_W-1:0] e0_user_reg, e1_user_reg;
    logic              push, pop;

    assign push     = en & dv_vld;
    assign pop      = m_tvalid & m_tready;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = e0_data_reg;
    assign m_tuser  = e0_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push && pop) begin
            e0_data_reg <= (cnt_reg == 2'd1) ? fin_data : e1_data_reg;
            e0_user_reg <= (cnt_reg == 2'd1) ? fin_user : e1_user_reg;
            e1_data_reg <= fin_data;
            e1_user_reg <= fin_user;
        end else if (push) begin
            if (cnt_reg == 2'd0) begin
                e0_data_reg <= fin_data;
                e0_user_reg <= fin_user;
            end else begin
                e1_data_reg <= fin_data;
                e1_user_reg <= fin_user;
            end
        end else if (pop) begin
            // advance the second beat to the head
            e0_data_reg <= e1_data_reg;
            e0_user_reg <= e1_user_reg;
        end
    end

endmodule

### sv/sfg_sqrt.sv
module sfg_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_vld,
    input  logic [sfg_pkg::SUM_W-1:0]    in_rad,
    input  sfg_pkg::sq_tag_t             in_tag,
    output logic                         out_vld,
    output logic [sfg_pkg::LEN_W-1:0]    out_root,
    output sfg_pkg::sq_tag_t             out_tag
);
    import sfg_pkg::*;

    localparam int RW = LEN_W;

    logic            vld_reg  [RW];
    logic [SUM_W-1:0] rad_reg [RW];
    logic [RW:0]     rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    sq_tag_t         tag_reg  [RW];

    logic            vld_next  [RW];
    logic [SUM_W-1:0] rad_next [RW];
    logic [RW:0]     rem_next  [RW];
    logic [RW-1:0]   root_next [RW];
    sq_tag_t         tag_next  [RW];

    logic            vld_prev  [RW];
    logic [SUM_W-1:0] rad_prev [RW];
    logic [RW:0]     rem_prev  [RW];
    logic [RW-1:0]   root_prev [RW];
    sq_tag_t         tag_prev  [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_stage
            logic [RW+1:0] rem_sh;
            logic [RW+1:0] trial;
            logic [RW+1:0] diff;
            logic          ge;

            if (k == 0) begin : g_first
                assign vld_prev[k]  = in_vld;
                assign rad_prev[k]  = in_rad;
                assign rem_prev[k]  = '0;
                assign root_prev[k] = '0;
                assign tag_prev[k]  = in_tag;
            end else begin : g_rest
                assign vld_prev[k]  = vld_reg[k-1];
                assign rad_prev[k]  = rad_reg[k-1];
                assign rem_prev[k]  = rem_reg[k-1];
                assign root_prev[k] = root_reg[k-1];
                assign tag_prev[k]  = tag_reg[k-1];
            end

            // one root bit: bring down two radicand bits, try 4*root+1
            always_comb begin
                rem_sh       = {rem_prev[k][RW-1:0], rad_prev[k][SUM_W-1 -: 2]};
                trial        = {root_prev[k], 2'b01};
                diff         = rem_sh - trial;
                ge           = (rem_sh >= trial);
                vld_next[k]  = vld_prev[k];
                rad_next[k]  = {rad_prev[k][SUM_W-3:0], 2'b00};
                rem_next[k]  = ge ? diff[RW:0] : rem_sh[RW:0];
                root_next[k] = {root_prev[k][RW-2:0], ge};
                tag_next[k]  = tag_prev[k];
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_next[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k]  <= rad_next[k];
                    rem_reg[k]  <= rem_next[k];
                    root_reg[k] <= root_next[k];
                    tag_reg[k]  <= tag_next[k];
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[RW-1];
    assign out_root = root_reg[RW-1];
    assign out_tag  = tag_reg[RW-1];

endmodule

### sv/sfg_div.sv
module sfg_div #(
    parameter int DEN_W = sfg_pkg::LEN_W + sfg_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_vld,
    input  logic [sfg_pkg::NUM_W-1:0]    in_num [sfg_pkg::NL],
    input  logic [DEN_W-1:0]             in_den,
    input  sfg_pkg::div_tag_t            in_tag,
    output logic                         out_vld,
    output logic [sfg_pkg::Q_W-1:0]      out_q  [sfg_pkg::NL],
    output logic [sfg_pkg::NL-1:0]       out_ovf,
    output sfg_pkg::div_tag_t            out_tag
);
    import sfg_pkg::*;

    // prologue stage takes the overflow test, then one quotient bit a stage
    localparam int NS   = Q_W + 1;
    localparam int HI_W = NUM_W - Q_W;

    logic             vld_reg [NS];
    logic [DEN_W-1:0] den_reg [NS];
    div_tag_t         tag_reg [NS];
    logic [DEN_W-1:0] rem_reg [NS][NL];
    logic [Q_W-1:0]   low_reg [NS][NL];
    logic [Q_W-1:0]   q_reg   [NS][NL];
    logic [NL-1:0]    ovf_reg [NS];

    logic             vld_next [NS];
    logic [DEN_W-1:0] den_next [NS];
    div_tag_t         tag_next [NS];
    logic [DEN_W-1:0] rem_next [NS][NL];
    logic [Q_W-1:0]   low_next [NS][NL];
    logic [Q_W-1:0]   q_next   [NS][NL];
    logic [NL-1:0]    ovf_next [NS];

    genvar k, i;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            if (k == 0) begin : g_pro
                always_comb begin
                    vld_next[k] = in_vld;
                    den_next[k] = in_den;
                    tag_next[k] = in_tag;
                end
                for (i = 0; i < NL; i++) begin : g_lane
                    logic [HI_W-1:0] hi;
                    always_comb begin
                        hi             = in_num[i][NUM_W-1:Q_W];
                        ovf_next[k][i] = (hi >= {{(HI_W-DEN_W){1'b0}}, in_den});
                        rem_next[k][i] = hi[DEN_W-1:0];
                        low_next[k][i] = in_num[i][Q_W-1:0];
                        q_next[k][i]   = '0;
                    end
                end
            end else begin : g_bit
                always_comb begin
                    vld_next[k] = vld_reg[k-1];
                    den_next[k] = den_reg[k-1];
                    tag_next[k] = tag_reg[k-1];
                    ovf_next[k] = ovf_reg[k-1];
                end
                for (i = 0; i < NL; i++) begin : g_lane
                    logic [DEN_W:0] rem_sh;
                    logic [DEN_W:0] diff;
                    logic           ge;
                    always_comb begin
                        rem_sh = {rem_reg[k-1][i], low_reg[k-1][i][Q_W-1]};
                        diff   = rem_sh - {1'b0, den_reg[k-1]};
                        ge     = (rem_sh >= {1'b0, den_reg[k-1]});
                        rem_next[k][i] = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                        low_next[k][i] = {low_reg[k-1][i][Q_W-2:0], 1'b0};
                        q_next[k][i]   = {q_reg[k-1][i][Q_W-2:0], ge};
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_next[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    den_reg[k] <= den_next[k];
                    tag_reg[k] <= tag_next[k];
                    ovf_reg[k] <= ovf_next[k];
                    for (int j = 0; j < NL; j++) begin
                        rem_reg[k][j] <= rem_next[k][j];
                        low_reg[k][j] <= low_next[k][j];
                        q_reg[k][j]   <= q_next[k][j];
                    end
                end
            end
        end
    endgenerate

    assign out_vld = vld_reg[NS-1];
    assign out_ovf = ovf_reg[NS-1];
    assign out_tag = tag_reg[NS-1];
    always_comb begin
        for (int j = 0; j < NL; j++) begin
            out_q[j] = q_reg[NS-1][j];
        end
    end

endmodule
